// File: hw/rtl/ekde_pkg.sv
package ekde_pkg;

  localparam int unsigned ValW  = 18;
  localparam int unsigned AccW  = 40;
  localparam int unsigned DistW = 56;

  // 5.0 in Q.48, 1/5 reciprocal (exact for dividends below 2^32), 4.0 in Q.24
  localparam logic [DistW-1:0] FiveQ48 = DistW'(5) << 48;
  localparam logic [31:0]      Recip5  = 32'hCCCC_CCCD;
  localparam logic [26:0]      SClamp  = 27'd1 << 26;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_CONST = 2'd1,
    CFG_SCALE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SQ,
    ST_DIV,
    ST_KMUL,
    ST_SCALE,
    ST_OUT
  } back_state_e;

  // classified word handed from front to back
  typedef struct packed {
    logic                   wr_en;
    logic                   comp_en;
    logic                   last;
    logic [2:0]             row;
    logic [2:0]             col;
    logic signed [ValW-1:0] value;
  } op_t;

endpackage

// File: hw/rtl/ekde_in_if.sv
interface ekde_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [17:0] value;
  logic               last;

  modport source (output valid, func, row, col, value, last, input ready);
  modport sink   (input valid, func, row, col, value, last, output ready);
endinterface

// File: hw/rtl/ekde_out_if.sv
interface ekde_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] density;
  logic        saturated;

  modport source (output valid, density, saturated, input ready);
  modport sink   (input valid, density, saturated, output ready);
endinterface

// File: hw/rtl/epanechnikov_kernel_eval_core.sv
// Epanechnikov kernel evaluator. Matrix entry writes and pattern components
// enter a two-word queue; the back unit holds the lower-triangle inverse
// matrix in a small memory and one multiply-accumulate path. An entry write
// and a plain-mode component are each handled in the idle state, and a
// shape-adaptive component takes one matrix read and multiply per row
// through the shared multiplier. After the last component the back unit
// squares and sums the accumulators, scales by 1/5, and applies the constant
// and, in shape-adaptive mode, the scale factor; the result then sits in an
// output register while the next words are taken. Rows and columns beyond
// min(DIM_MAX,8) are ignored.
module epanechnikov_kernel_eval_core #(
  parameter int unsigned DIM_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  ekde_in_if.sink     in_i,
  ekde_out_if.source  out_o
);
  import ekde_pkg::*;

  localparam int unsigned DimUsed = (DIM_MAX < 8) ? DIM_MAX : 8;

  logic        mode_q;
  logic [23:0] kconst_q;
  logic [31:0] scale_q;
  op_t         op;
  logic        op_valid, op_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      kconst_q <= '0;
      scale_q  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:  mode_q   <= cfg_data_i[0];
        CFG_CONST: kconst_q <= cfg_data_i[23:0];
        CFG_SCALE: scale_q  <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  ekde_front #(.DimUsed(DimUsed)) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .op_o       (op),
    .op_valid_o (op_valid),
    .op_pop_i   (op_pop)
  );

  ekde_back #(.DimUsed(DimUsed)) u_back (
    .clk_i,
    .rst_ni,
    .mode_i     (mode_q),
    .kconst_i   (kconst_q),
    .scale_i    (scale_q),
    .op_i       (op),
    .op_valid_i (op_valid),
    .op_pop_o   (op_pop),
    .out_o
  );

endmodule

// File: hw/rtl/ekde_front.sv
module ekde_front #(
  parameter int unsigned DimUsed = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ekde_in_if.sink           in_i,
  output ekde_pkg::op_t     op_o,
  output logic              op_valid_o,
  input  logic              op_pop_i
);
  import ekde_pkg::*;

  op_t        q_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  op_t        op_new;
  logic       push;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = q_q[rptr_q];

  always_comb begin
    op_new.wr_en   = !in_i.func && (32'(in_i.row) < DimUsed) && (32'(in_i.col) < DimUsed)
                     && (in_i.row >= in_i.col);
    op_new.comp_en = in_i.func && (32'(in_i.col) < DimUsed);
    op_new.last    = in_i.func && in_i.last;
    op_new.row     = in_i.row;
    op_new.col     = in_i.col;
    op_new.value   = in_i.value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (op_pop_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(op_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wptr_q] <= op_new;
  end

endmodule

// File: hw/rtl/ekde_back.sv
module ekde_back #(
  parameter int unsigned DimUsed = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          mode_i,
  input  logic [23:0]   kconst_i,
  input  logic [31:0]   scale_i,
  input  ekde_pkg::op_t op_i,
  input  logic          op_valid_i,
  output logic          op_pop_o,
  ekde_out_if.source    out_o
);
  import ekde_pkg::*;

  localparam int unsigned CntW = $clog2(DimUsed + 1);

  back_state_e state_q, state_d;

  logic signed [AccW-1:0] sum_q [DimUsed];
  logic signed [ValW-1:0] mem [64];
  logic signed [ValW-1:0] rd_q;
  logic signed [35:0]     prod_q;
  logic                   rd_v_q, mul_v_q, sq_v_q;
  logic [CntW-1:0]        cnt_q;
  op_t                    cur_q;
  logic [53:0]            sq_q;
  logic [DistW-1:0]       d_q;
  logic [24:0]            t_q;
  logic [23:0]            k_q;
  logic [31:0]            res_q;
  logic                   sat_q;
  logic                   ovalid_q;
  logic [31:0]            dens_q;
  logic                   osat_q;

  logic                   issue, mac_done, sq_done, out_load;
  logic [2:0]             rrow, arow, acol;
  logic [AccW-1:0]        mag;
  logic [26:0]            amag;
  logic [DistW-1:0]       diff;
  logic [58:0]            qprod;
  logic [48:0]            kprod;
  logic [55:0]            sprod;

  assign issue    = (32'(cnt_q) < DimUsed);
  assign mac_done = !issue && !rd_v_q && !mul_v_q;
  assign sq_done  = !issue && !sq_v_q;
  assign out_load = (state_q == ST_OUT) && (!ovalid_q || out_o.ready);

  // mirrored lower-triangle address
  assign rrow = 3'(cnt_q);
  assign arow = (rrow >= cur_q.col) ? rrow : cur_q.col;
  assign acol = (rrow >= cur_q.col) ? cur_q.col : rrow;

  assign mag   = sum_q[0][AccW-1] ? AccW'(-sum_q[0]) : AccW'(sum_q[0]);
  assign amag  = (mag > AccW'(SClamp)) ? SClamp : mag[26:0];
  assign diff  = FiveQ48 - d_q;
  assign qprod = 59'(diff[50:24]) * 59'(Recip5);
  assign kprod = 49'(kconst_i) * 49'(t_q);
  assign sprod = 56'(k_q) * 56'(scale_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          if (op_i.comp_en && mode_i) state_d = ST_MAC;
          else if (op_i.last)         state_d = ST_SQ;
        end
      end
      ST_MAC:   if (mac_done) state_d = cur_q.last ? ST_SQ : ST_IDLE;
      ST_SQ:    if (sq_done) state_d = ST_DIV;
      ST_DIV:   state_d = ST_KMUL;
      ST_KMUL:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_OUT;
      ST_OUT:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_pop_o = (state_q == ST_IDLE) && op_valid_i;
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.density   = dens_q;
  assign out_o.saturated = osat_q;

  function automatic logic op_pop_i_mode0();
    return op_valid_i && op_i.comp_en && !mode_i;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_v_q   <= 1'b0;
      mul_v_q  <= 1'b0;
      sq_v_q   <= 1'b0;
      ovalid_q <= 1'b0;
      for (int j = 0; j < DimUsed; j++) sum_q[j] <= '0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_MAC) && issue;
      mul_v_q <= rd_v_q;
      sq_v_q  <= (state_q == ST_SQ) && issue;
      if (out_load) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;

      if (state_q == ST_IDLE) begin
        cnt_q <= '0;
        if (op_pop_i_mode0()) begin
          for (int j = 0; j < DimUsed; j++) begin
            if (op_i.col == 3'(j)) sum_q[j] <= AccW'(op_i.value) <<< 12;
          end
        end
      end else if (state_q == ST_MAC) begin
        if (issue) cnt_q <= cnt_q + CntW'(1);
        else if (mac_done) cnt_q <= '0;
        // rows finish in order: add into the head and rotate
        if (mul_v_q) begin
          for (int j = 0; j + 1 < DimUsed; j++) sum_q[j] <= sum_q[j+1];
          sum_q[DimUsed-1] <= sum_q[0] + AccW'(prod_q);
        end
      end else if (state_q == ST_SQ) begin
        if (issue) begin
          cnt_q <= cnt_q + CntW'(1);
          // drain with zero fill, which also clears for the next pattern
          for (int j = 0; j + 1 < DimUsed; j++) sum_q[j] <= sum_q[j+1];
          sum_q[DimUsed-1] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.wr_en) mem[{op_i.row, op_i.col}] <= op_i.value;
    rd_q   <= mem[{arow, acol}];
    prod_q <= rd_q * cur_q.value;
    if (op_pop_o) cur_q <= op_i;
    sq_q <= 54'(amag) * 54'(amag);
    if (state_q != ST_SQ) d_q <= '0;
    else if (sq_v_q) d_q <= d_q + DistW'(sq_q);
    if (state_q == ST_DIV) t_q <= (d_q >= FiveQ48) ? 25'd0 : qprod[58:34];
    if (state_q == ST_KMUL) k_q <= kprod[47:24];
    if (state_q == ST_SCALE) begin
      if (mode_i) begin
        sat_q <= |sprod[55:48];
        res_q <= (|sprod[55:48]) ? 32'hFFFF_FFFF : sprod[47:16];
      end else begin
        sat_q <= 1'b0;
        res_q <= 32'(k_q);
      end
    end
    if (out_load) begin
      dens_q <= res_q;
      osat_q <= sat_q;
    end
  end

endmodule

// File: tb/epanechnikov_kernel_eval_core_tb.sv
module epanechnikov_kernel_eval_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ekde_pkg::*;

  localparam bit FUNC_MAT  = 1'b0;
  localparam bit FUNC_COMP = 1'b1;
  localparam int unsigned DIM = 8;
  localparam int unsigned SETTLE_CYC = 64;
  localparam int unsigned ITEM_TARGET = 800;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } dens_t;

  typedef struct packed {
    logic               func;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [17:0] value;
    logic               last;
    logic               typed;
    logic [31:0]        density;
    logic               saturated;
  } stim_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  ekde_in_if  in_if ();
  ekde_out_if out_if ();

  epanechnikov_kernel_eval_core #(.DIM_MAX(DIM)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  // shadow of the block state
  logic signed [17:0] inv_m [DIM][DIM];
  logic signed [39:0] acc [DIM];
  logic               mode_q;
  logic [23:0]        kconst_q;
  logic [31:0]        scale_q;

  dens_t density_q [$];
  int unsigned fails;
  int unsigned items_sent;

  // directed words, run with mode 0 and the constant at full scale
  stim_t dir_tab [14] = '{
    '{FUNC_COMP, 3'd0, 3'd0, 18'sd0,       1'b1, 1'b1, 32'h00FF_FFFF, 1'b0},
    '{FUNC_COMP, 3'd0, 3'd0, 18'sd131071,  1'b1, 1'b1, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd7, -18'sd131072, 1'b1, 1'b1, 32'h0,         1'b0},
    '{FUNC_MAT,  3'd7, 3'd0, 18'sd131071,  1'b1, 1'b0, 32'h0,         1'b0},
    '{FUNC_MAT,  3'd0, 3'd7, -18'sd131072, 1'b0, 1'b0, 32'h0,         1'b0},
    '{FUNC_MAT,  3'd7, 3'd7, -18'sd131072, 1'b0, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd7, 3'd1, 18'sd4096,    1'b0, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd1, -18'sd2048,   1'b0, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd2, 18'sd1000,    1'b0, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd3, -18'sd1,      1'b1, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd5, 18'sd4096,    1'b1, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd4, 18'sd9158,    1'b1, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd6, 18'sd9159,    1'b1, 1'b0, 32'h0,         1'b0},
    '{FUNC_COMP, 3'd0, 3'd0, 18'sd0,       1'b1, 1'b1, 32'h00FF_FFFF, 1'b0}
  };

  function automatic logic signed [17:0] entry_of(int unsigned r, int unsigned c);
    if (r >= c) begin
      return inv_m[r][c];
    end
    return inv_m[c][r];
  endfunction

  function automatic dens_t kernel_density();
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] k;
    logic [63:0] dens;
    longint      s;
    dens_t       res;
    d = '0;
    for (int i = 0; i < DIM; i++) begin
      s = longint'(acc[i]);
      if (s < 0) s = -s;
      if (s > (longint'(1) << 26)) s = longint'(1) << 26;
      a = 64'(s);
      d += a * a;
    end
    if (d >= (64'd5 << 48)) begin
      k = '0;
    end else begin
      t = ((64'd5 << 48) - d) / (64'd5 << 24);
      k = (64'(kconst_q) * t) >> 24;
    end
    dens = mode_q ? (k * 64'(scale_q)) >> 16 : k;
    res.saturated = dens > 64'hFFFF_FFFF;
    res.density   = res.saturated ? 32'hFFFF_FFFF : dens[31:0];
    return res;
  endfunction

  // advances the shadow state by one word; returns 1 when a result follows
  function automatic bit apply_word(stim_t w, output dens_t res);
    longint p;
    res = '0;
    if (w.func == FUNC_MAT) begin
      if (w.row >= w.col) inv_m[w.row][w.col] = w.value;
      return 1'b0;
    end
    if (mode_q) begin
      for (int r = 0; r < DIM; r++) begin
        p = longint'(entry_of(r, w.col)) * longint'(w.value);
        acc[r] = acc[r] + p[39:0];
      end
    end else begin
      p = longint'(w.value) * 4096;
      acc[w.col] = p[39:0];
    end
    if (!w.last) return 1'b0;
    res = kernel_density();
    for (int i = 0; i < DIM; i++) acc[i] = '0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(stim_t w);
    int unsigned gap;
    bit          has;
    dens_t       res;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.func  <= w.func;
    in_if.row   <= w.row;
    in_if.col   <= w.col;
    in_if.value <= w.value;
    in_if.last  <= w.last;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    has = apply_word(w, res);
    if (has) density_q.push_back(w.typed ? dens_t'({w.density, w.saturated}) : res);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (density_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE:  mode_q   = data[0];
      CFG_CONST: kconst_q = data[23:0];
      CFG_SCALE: scale_q  = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [17:0] rand_value(int unsigned cls);
    case (cls)
      0:       return 18'($signed($urandom_range(1024)) - 512);
      1:       return 18'($signed($urandom_range(8192)) - 4096);
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_class();
    int unsigned roll;
    roll = $urandom_range(99);
    return (roll < 50) ? 0 : (roll < 85) ? 1 : 2;
  endfunction

  task automatic fill_matrix(bit wide);
    stim_t w;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c <= r; c++) begin
        w = '0;
        w.func  = FUNC_MAT;
        w.row   = 3'(r);
        w.col   = 3'(c);
        w.value = wide ? rand_value(2) : rand_value($urandom_range(1));
        w.last  = 1'($urandom_range(1));
        send_word(w);
      end
    end
  endtask

  task automatic send_pattern(bit close);
    stim_t       w;
    int unsigned len;
    int unsigned cls;
    len = $urandom_range(DIM, 1);
    cls = pick_class();
    for (int i = 0; i < len; i++) begin
      // stray matrix writes, upper triangle included
      if ($urandom_range(9) == 0) begin
        w = '0;
        w.func  = FUNC_MAT;
        w.row   = 3'($urandom);
        w.col   = 3'($urandom);
        w.value = rand_value(pick_class());
        w.last  = 1'($urandom_range(1));
        send_word(w);
      end
      w = '0;
      w.func  = FUNC_COMP;
      w.row   = 3'($urandom);
      w.col   = 3'($urandom);
      w.value = rand_value(cls);
      w.last  = close && (i == len - 1);
      send_word(w);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // result sink with random stalls
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_if.ready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(posedge clk_i);
      if ($urandom_range(3) != 0) begin
        out_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    dens_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (density_q.size() == 0) begin
        $error("unexpected word: density %h saturated %b", out_if.density, out_if.saturated);
        fails++;
      end else begin
        want = density_q.pop_front();
        if (out_if.density !== want.density) begin
          $error("density: expected %h, got %h", want.density, out_if.density);
          fails++;
        end
        if (out_if.saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, out_if.saturated);
          fails++;
        end
      end
    end
  end

  initial begin
    int unsigned phase;
    logic        pm;
    logic [23:0] pk;
    logic [31:0] ps;
    fails = 0;
    items_sent = 0;
    for (int r = 0; r < DIM; r++) begin
      acc[r] = '0;
      for (int c = 0; c < DIM; c++) inv_m[r][c] = '0;
    end
    mode_q   = 1'b0;
    kconst_q = '0;
    scale_q  = 32'd65536;
    cfg_we   = 1'b0;
    cfg_idx  = CFG_MODE;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.func  = FUNC_MAT;
    in_if.row   = '0;
    in_if.col   = '0;
    in_if.value = '0;
    in_if.last  = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_MODE, 32'd0);
    write_reg(CFG_CONST, 32'h00FF_FFFF);
    foreach (dir_tab[i]) send_word(dir_tab[i]);
    wait_drained();

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0:       begin pm = 1'b1; pk = 24'hFF_FFFF; ps = 32'hFFFF_FFFF; end
        1:       begin pm = 1'b0; pk = 24'h0;       ps = 32'h0;         end
        2:       begin pm = 1'b1; pk = 24'h80_0000; ps = 32'd1;         end
        3:       begin pm = 1'b1; pk = 24'h0;       ps = 32'd65536;     end
        default: begin pm = 1'($urandom_range(1)); pk = 24'($urandom); ps = $urandom; end
      endcase
      write_reg(CFG_MODE, 32'(pm));
      write_reg(CFG_CONST, 32'(pk));
      write_reg(CFG_SCALE, ps);
      if (pm) fill_matrix(phase == 3);
      for (int n = 0; n < 30; n++) send_pattern(1'b1);
      // sometimes leave a pattern open across the mode change
      if ($urandom_range(1)) send_pattern(1'b0);
      wait_drained();
      phase++;
    end
    send_pattern(1'b1);
    wait_drained();

    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ekde_pkg.sv
hw/rtl/ekde_in_if.sv
hw/rtl/ekde_out_if.sv
hw/rtl/ekde_front.sv
hw/rtl/ekde_back.sv
hw/rtl/epanechnikov_kernel_eval_core.sv
tb/epanechnikov_kernel_eval_core_tb.sv
